// ===== rtl/eia_pkg.sv =====
// Shared types and constants for the endpoint ID allocator.
package eia_pkg;

   localparam int KEY_W  = 24;
   localparam int ID_W   = 16;
   localparam int DEV_W  = 16;
   localparam int INST_W = 8;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_GET     = 2'd1,
      REQ_REVERSE = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_NEW       = 2'd0,
      STAT_FOUND     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REV_CHECK,
      ST_REV_READ,
      ST_FINISH
   } state_type;

   localparam logic CSR_START_ID = 1'b0;
   localparam logic [ID_W-1:0] START_ID_RESET = 16'd1;

endpackage

// ===== rtl/eia_table.sv =====
// Address table memory: one write port, one registered read port.
module eia_table import eia_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [KEY_W-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] mem [TABLE_ENTRIES];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/eia_ctrl.sv =====
// Sequencer: linear table search, allocation and reverse lookup.
module eia_ctrl import eia_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ID_W-1:0]   start_id,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [DEV_W-1:0]  req_device_id,
   input  logic [INST_W-1:0] req_instance_req,
   input  logic [ID_W-1:0]   req_query_id,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_endpoint_id,
   output logic [DEV_W-1:0]  rsp_found_device,
   output logic [INST_W-1:0] rsp_found_instance,
   output logic              tbl_wr_en,
   output logic [IDX_W-1:0]  tbl_wr_addr,
   output logic [KEY_W-1:0]  tbl_wr_data,
   output logic [IDX_W-1:0]  tbl_rd_addr,
   input  logic [KEY_W-1:0]  tbl_rd_data
);

   state_type state_ff, state_in;

   logic [1:0]        kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [ID_W-1:0]   qid_ff, qid_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [ID_W-1:0]   res_eid_ff, res_eid_in;
   logic [KEY_W-1:0]  res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [ID_W-1:0]   rsp_eid_ff;
   logic [KEY_W-1:0]  rsp_addr_ff;

   logic              accept;
   logic              issue;
   logic              hit;
   logic              scan_done;
   logic              rsp_load;
   logic [ID_W:0]     alloc_sum;
   logic [ID_W:0]     offset;
   logic              rev_hit;

   assign accept    = req_valid && !req_stall;
   assign issue     = (issue_ff < count_ff);
   assign hit       = cmp_valid_ff && (tbl_rd_data == key_ff);
   assign scan_done = !hit && !cmp_valid_ff && !issue;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign alloc_sum = {1'b0, start_id} + {{(ID_W+1-CNT_W){1'b0}}, count_ff};
   assign offset    = {1'b0, qid_ff} - {1'b0, start_id};
   assign rev_hit   = !offset[ID_W] &&
                      (offset[ID_W-1:0] < {{(ID_W-CNT_W){1'b0}}, count_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind_type'(req_type))
                  REQ_ALLOC, REQ_GET: state_in = ST_SCAN;
                  REQ_REVERSE:        state_in = ST_REV_CHECK;
                  default:            state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit || scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_REV_CHECK: begin
            state_in = rev_hit ? ST_REV_READ : ST_FINISH;
         end
         ST_REV_READ: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      kind_in       = kind_ff;
      key_in        = key_ff;
      qid_in        = qid_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      res_status_in = res_status_ff;
      res_eid_in    = res_eid_ff;
      res_addr_in   = res_addr_ff;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = count_ff[IDX_W-1:0];
      tbl_wr_data   = key_ff;
      tbl_rd_addr   = issue_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_type;
               key_in        = {req_device_id, req_instance_req};
               qid_in        = req_query_id;
               issue_in      = '0;
               res_status_in = STAT_NOT_FOUND;
               res_eid_in    = '0;
               res_addr_in   = '0;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = issue;
            cmp_idx_in   = issue_ff[IDX_W-1:0];
            if (issue) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (hit) begin
               res_status_in = STAT_FOUND;
               res_eid_in    = start_id + {{(ID_W-IDX_W){1'b0}}, cmp_idx_ff};
            end else if (scan_done && (req_kind_type'(kind_ff) == REQ_ALLOC)) begin
               if ((count_ff == CNT_W'(TABLE_ENTRIES)) || alloc_sum[ID_W]) begin
                  res_status_in = STAT_FULL;
               end else begin
                  tbl_wr_en     = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  res_status_in = STAT_NEW;
                  res_eid_in    = alloc_sum[ID_W-1:0];
               end
            end
         end
         ST_REV_CHECK: begin
            tbl_rd_addr = offset[IDX_W-1:0];
         end
         ST_REV_READ: begin
            res_status_in = STAT_FOUND;
            res_eid_in    = qid_ff;
            res_addr_in   = tbl_rd_data;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      qid_ff        <= qid_in;
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_eid_ff    <= res_eid_in;
      res_addr_ff   <= res_addr_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_eid_ff    <= res_eid_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_endpoint_id    = rsp_eid_ff;
   assign rsp_found_device   = rsp_addr_ff[KEY_W-1:INST_W];
   assign rsp_found_instance = rsp_addr_ff[INST_W-1:0];

endmodule

// ===== rtl/endpoint_id_allocator_top.sv =====
// Endpoint ID allocator top level: register port, sequencer and address table.
// Allocate/get searches the table linearly, one table read per cycle through the
// registered read port, and stops early on a hit; reverse lookup range-checks the query
// ID and reads one entry only on a hit, and an unused request type goes straight to the result.
// The next transaction can be accepted in the same cycle as the result turns valid; an
// untaken result holds the next one in its final state.
// Synchronous reset empties the table (entry count zero) and sets start_id to 1.
module endpoint_id_allocator_top import eia_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [DEV_W-1:0]  req_device_id,
   input  logic [INST_W-1:0] req_instance_req,
   input  logic [ID_W-1:0]   req_query_id,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_endpoint_id,
   output logic [DEV_W-1:0]  rsp_found_device,
   output logic [INST_W-1:0] rsp_found_instance
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [ID_W-1:0]  start_id_ff, start_id_in;
   logic             csr_write;
   logic             tbl_wr_en;
   logic [IDX_W-1:0] tbl_wr_addr;
   logic [KEY_W-1:0] tbl_wr_data;
   logic [IDX_W-1:0] tbl_rd_addr;
   logic [KEY_W-1:0] tbl_rd_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      start_id_in = start_id_ff;
      if (csr_write && (paddr[2] == CSR_START_ID)) begin
         start_id_in = pwdata[ID_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_START_ID) begin
         prdata = {{(32-ID_W){1'b0}}, start_id_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_id_ff <= START_ID_RESET;
      end else begin
         start_id_ff <= start_id_in;
      end
   end

   eia_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start_id           (start_id_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_device_id      (req_device_id),
      .req_instance_req   (req_instance_req),
      .req_query_id       (req_query_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_endpoint_id    (rsp_endpoint_id),
      .rsp_found_device   (rsp_found_device),
      .rsp_found_instance (rsp_found_instance),
      .tbl_wr_en          (tbl_wr_en),
      .tbl_wr_addr        (tbl_wr_addr),
      .tbl_wr_data        (tbl_wr_data),
      .tbl_rd_addr        (tbl_rd_addr),
      .tbl_rd_data        (tbl_rd_data)
   );

   eia_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

endmodule

// ===== dv/tb_endpoint_id_allocator_top.sv =====
// Testbench for the endpoint ID allocator: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb_endpoint_id_allocator_top import eia_pkg::*;;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDLE_PCT = 38;
   localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;
   localparam logic [2:0] START_ID_ADDR = {CSR_START_ID, 2'b00};
   localparam logic [2:0] SPARE_ADDR = 3'd4;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   endpoint_id;
      logic [DEV_W-1:0]  device;
      logic [INST_W-1:0] inst;
   } lookup_answer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type = '0;
   logic [DEV_W-1:0]  req_device_id = '0;
   logic [INST_W-1:0] req_instance_req = '0;
   logic [ID_W-1:0]   req_query_id = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [ID_W-1:0]   rsp_endpoint_id;
   logic [DEV_W-1:0]  rsp_found_device;
   logic [INST_W-1:0] rsp_found_instance;

   // predictor state
   logic [KEY_W-1:0] key_store [TABLE_ENTRIES];
   int               stored_count = 0;
   logic [ID_W-1:0]  first_id = START_ID_RESET;

   lookup_answer_type pending_answers[$];
   int                mismatches = 0;
   bit                steady = 1'b0;

   endpoint_id_allocator_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (.*);

   always #2 clock = ~clock;

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   function automatic lookup_answer_type predict_lookup(req_kind_type kind,
                                                       logic [DEV_W-1:0] dev,
                                                       logic [INST_W-1:0] inst,
                                                       logic [ID_W-1:0] qid);
      lookup_answer_type ans;
      logic [KEY_W-1:0] key;
      int pos;
      int off;
      ans = '{STAT_NOT_FOUND, '0, '0, '0};
      key = {dev, inst};
      pos = -1;
      case (kind)
         REQ_ALLOC, REQ_GET: begin
            for (int i = 0; i < stored_count; i++) begin
               if (pos < 0 && key_store[i] == key) pos = i;
            end
            if (pos >= 0) begin
               ans.status = STAT_FOUND;
               ans.endpoint_id = ID_W'(int'(first_id) + pos);
            end else if (kind == REQ_ALLOC) begin
               if (stored_count >= TABLE_ENTRIES || int'(first_id) + stored_count > 65535) begin
                  ans.status = STAT_FULL;
               end else begin
                  key_store[stored_count] = key;
                  ans.status = STAT_NEW;
                  ans.endpoint_id = ID_W'(int'(first_id) + stored_count);
                  stored_count++;
               end
            end
         end
         REQ_REVERSE: begin
            off = int'(qid) - int'(first_id);
            if (off >= 0 && off < stored_count) begin
               ans.status = STAT_FOUND;
               ans.endpoint_id = qid;
               ans.device = key_store[off][KEY_W-1:INST_W];
               ans.inst = key_store[off][INST_W-1:0];
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // response checker
   always @(posedge clock) begin
      lookup_answer_type got;
      lookup_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{status_type'(rsp_status), rsp_endpoint_id, rsp_found_device, rsp_found_instance};
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with none expected: status %0d id %h dev %h inst %h",
                        $realtime, got.status, got.endpoint_id, got.device, got.inst);
         end else begin
            want = pending_answers.pop_front();
            if (got.status !== want.status || got.endpoint_id !== want.endpoint_id ||
                got.device !== want.device || got.inst !== want.inst) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("%0t: mismatch: exp status %0d id %h dev %h inst %h, ", $realtime,
                         want.status, want.endpoint_id, want.device, want.inst);
                  $display("got status %0d id %h dev %h inst %h",
                           got.status, got.endpoint_id, got.device, got.inst);
               end
            end
         end
      end
   end

   task automatic issue_request(req_kind_type kind, logic [DEV_W-1:0] dev,
                                logic [INST_W-1:0] inst, logic [ID_W-1:0] qid);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_device_id <= dev;
      req_instance_req <= inst;
      req_query_id <= qid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_answers.push_back(predict_lookup(kind, dev, inst, qid));
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == START_ID_ADDR) first_id = data[ID_W-1:0];
   endtask

   task automatic check_start_id_readback();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= START_ID_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[ID_W-1:0] !== first_id) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: start_id readback exp %h got %h", $realtime, first_id,
                     prdata[ID_W-1:0]);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_empty_table();
      issue_request(REQ_GET, 16'hFFFF, 8'hFF, 16'h0000);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, START_ID_RESET);
      issue_request(REQ_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
   endtask

   task automatic test_allocate_and_lookup();
      issue_request(REQ_ALLOC, 16'h0000, 8'h00, 16'hFFFF);
      issue_request(REQ_ALLOC, 16'hFFFF, 8'hFF, 16'h0000);
      issue_request(REQ_ALLOC, 16'h0000, 8'h00, 16'h0000);
      issue_request(REQ_ALLOC, 16'h1234, 8'h80, 16'h0000);
      issue_request(REQ_GET, 16'hFFFF, 8'hFF, 16'h0000);
      issue_request(REQ_GET, 16'hFFFF, 8'hFE, 16'h0000);
      issue_request(REQ_REVERSE, 16'hFFFF, 8'hFF, 16'h0000);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'h0001);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'h0002);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'h0003);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'h0004);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'hFFFF);
   endtask

   task automatic test_start_id_register();
      settle_idle();
      csr_write(SPARE_ADDR, 32'hFFFF_FFFF);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'h0003);
      settle_idle();
      csr_write(START_ID_ADDR, 32'hABCD_0000);
      check_start_id_readback();
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'h0000);
      issue_request(REQ_GET, 16'h0000, 8'h00, 16'h0000);
      settle_idle();
      // room for exactly one more ID, the top of the range
      csr_write(START_ID_ADDR, 32'h0000_FFFC);
      issue_request(REQ_ALLOC, 16'h8000, 8'h01, 16'h0000);
      issue_request(REQ_ALLOC, 16'h8000, 8'h02, 16'h0000);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'hFFFF);
      issue_request(REQ_GET, 16'hFFFF, 8'hFF, 16'h0000);
      settle_idle();
      csr_write(START_ID_ADDR, 32'h0000_FFFF);
      check_start_id_readback();
      issue_request(REQ_ALLOC, 16'h0000, 8'h00, 16'h0000);
      issue_request(REQ_GET, 16'h1234, 8'h80, 16'h0000);
      issue_request(REQ_ALLOC, 16'h5A5A, 8'h5A, 16'h0000);
      issue_request(REQ_REVERSE, 16'h0000, 8'h00, 16'hFFFF);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      k = KEY_W'($urandom);
      if (stored_count > 0 && $urandom_range(99) < 60) begin
         k = key_store[$urandom_range(stored_count - 1)];
         if ($urandom_range(9) == 0) k[$urandom_range(KEY_W - 1)] ^= 1'b1;
      end
      return k;
   endfunction

   task automatic test_random_traffic();
      logic [ID_W-1:0] phase_start [9];
      req_kind_type kind;
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0] qid;
      int roll;
      int off;
      phase_start = '{16'd1, 16'hFFF5, 16'd0, 16'd300, ID_W'($urandom_range(2000)),
                      16'hFFC0, 16'hFFFF, ID_W'($urandom), 16'd1};
      foreach (phase_start[p]) begin
         settle_idle();
         csr_write(START_ID_ADDR, {16'($urandom), phase_start[p]});
         steady = (p == 3);
         for (int n = 0; n < 120; n++) begin
            if (n == 60) settle_idle();
            roll = $urandom_range(99);
            kind = roll < 40 ? REQ_ALLOC : roll < 70 ? REQ_GET :
                   roll < 95 ? REQ_REVERSE : REQ_UNUSED;
            key = pick_key();
            off = $urandom_range(stored_count + 1);
            qid = $urandom_range(9) < 7 ? ID_W'(int'(first_id) + off - 1) : ID_W'($urandom);
            issue_request(kind, key[KEY_W-1:INST_W], key[INST_W-1:0], qid);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_allocate_and_lookup();
      test_start_id_register();
      test_random_traffic();
      settle_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
